// ===== hw/rtl/rotation_matrix_to_quaternion_unit_macros.svh =====
// Assertion macros for the rotation matrix to quaternion unit.
// Needs nothing else; taken in by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// Plain clocked property, switched off while reset is asserted.
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Whatever sig states must hold in the cycle after a stalled transaction.
`define RMQ_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  `RMQ_ASSERT(lbl, clk, rst_n, ((vld) && !(rdy)) |=> (sig), msg)

`endif

// ===== hw/rtl/rmq_pkg.sv =====
// Shared constants, types and width helpers of the rotation matrix to
// quaternion unit. Depends on nothing.
package rmq_pkg;

  localparam int FIELD_W         = 16;
  localparam int LANES           = 4;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int QUEUE_DEPTH_DEF = 2;

  // largest magnitude a quaternion part may carry
  localparam logic [FIELD_W-2:0] MAG_MAX = '1;

  // lane order in the back end
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } rmq_sign_t;

  localparam int SIGN_W = $bits(rmq_sign_t);

  // signed width of ONE plus three 16-bit entries
  function automatic int sum_width(int frac);
    return ((frac > FIELD_W - 1) ? frac : FIELD_W - 1) + 3;
  endfunction

  // root bits of the clamped sum shifted up by frac
  function automatic int root_width(int frac);
    return (sum_width(frac) - 1 + frac + 1) >> 1;
  endfunction

  // queue entry: signs and four clamped sums
  function automatic int entry_width(int frac);
    return LANES * (sum_width(frac) - 1) + SIGN_W;
  endfunction

endpackage

// ===== hw/rtl/rmq_if.sv =====
// Channel interfaces of the rotation matrix to quaternion unit: matrix in,
// quaternion out. Depends on nothing.
interface rmq_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m_right_x;
  logic signed [15:0] m_right_y;
  logic signed [15:0] m_right_z;
  logic signed [15:0] m_up_x;
  logic signed [15:0] m_up_y;
  logic signed [15:0] m_up_z;
  logic signed [15:0] m_fwd_x;
  logic signed [15:0] m_fwd_y;
  logic signed [15:0] m_fwd_z;

  modport source (
    output valid, m_right_x, m_right_y, m_right_z, m_up_x, m_up_y, m_up_z,
           m_fwd_x, m_fwd_y, m_fwd_z,
    input  ready
  );
  modport sink (
    input  valid, m_right_x, m_right_y, m_right_z, m_up_x, m_up_y, m_up_z,
           m_fwd_x, m_fwd_y, m_fwd_z,
    output ready
  );
endinterface

interface rmq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== hw/rtl/rmq_front.sv =====
// Front end: takes matrix transactions, forms the four clamped diagonal sums
// and the three sign flags, and pushes them into the queue. Uses rmq_pkg, rmq_if.
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  rmq_mat_if.sink                                  mat_i,
  output logic                                     push_valid_o,
  input  logic                                     push_ready_i,
  output logic [rmq_pkg::entry_width(FRAC_BITS)-1:0] push_data_o
);
  import rmq_pkg::*;

  localparam int SW = sum_width(FRAC_BITS);
  localparam int UW = SW - 1;

  logic signed [SW-1:0] one, rx, uy, fz;
  logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z;
  logic [UW-1:0]        cl_w, cl_x, cl_y, cl_z;
  logic signed [16:0]   dx, dy, dz;
  rmq_sign_t            sgn;

  function automatic logic [UW-1:0] clamp(logic signed [SW-1:0] v);
    return v[SW-1] ? '0 : v[UW-1:0];
  endfunction

  assign one = SW'(1) <<< FRAC_BITS;
  assign rx  = SW'(mat_i.m_right_x);
  assign uy  = SW'(mat_i.m_up_y);
  assign fz  = SW'(mat_i.m_fwd_z);

  assign sum_w = one + rx + uy + fz;
  assign sum_x = one + rx - uy - fz;
  assign sum_y = one - rx + uy - fz;
  assign sum_z = one - rx - uy + fz;

  assign cl_w = clamp(sum_w);
  assign cl_x = clamp(sum_x);
  assign cl_y = clamp(sum_y);
  assign cl_z = clamp(sum_z);

  // zero difference counts as positive
  assign dx = 17'(mat_i.m_fwd_y)   - 17'(mat_i.m_up_z);
  assign dy = 17'(mat_i.m_right_z) - 17'(mat_i.m_fwd_x);
  assign dz = 17'(mat_i.m_up_x)    - 17'(mat_i.m_right_y);

  assign sgn.neg_x = dx[16];
  assign sgn.neg_y = dy[16];
  assign sgn.neg_z = dz[16];

  assign push_valid_o = mat_i.valid;
  assign mat_i.ready  = push_ready_i;
  assign push_data_o  = {sgn, cl_w, cl_x, cl_y, cl_z};

endmodule

// ===== hw/rtl/rmq_queue.sv =====
// Short register FIFO between front and back end.
// Uses no package items.
module rmq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= bump(wr_q);
      if (pop)  rd_q <= bump(rd_q);
      if (push && !pop)      cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/rmq_back.sv =====
// Back end: four square-root lanes, one root bit per stage, then halving,
// saturation, sign and the output register. Uses rmq_pkg, rmq_if.
module rmq_back #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     pop_valid_i,
  output logic                                     pop_ready_o,
  input  logic [rmq_pkg::entry_width(FRAC_BITS)-1:0] pop_data_i,
  rmq_quat_if.source                               quat_o
);
  import rmq_pkg::*;

  localparam int UW = sum_width(FRAC_BITS) - 1;
  localparam int RW = root_width(FRAC_BITS);
  localparam int EW = entry_width(FRAC_BITS);
  localparam int HW = RW - 1;
  localparam int XW = (HW > FIELD_W) ? HW : FIELD_W;
  localparam int TW = 2 * RW + 2;

  // stage pipeline
  logic             vld_q [RW];
  rmq_sign_t        sgn_q [RW];
  logic [2*RW-1:0]  rad_q [LANES][RW-1];
  logic [RW+1:0]    rem_q [LANES][RW-1];
  logic [RW-1:0]    root_q [LANES][RW];
  logic [TW-1:0]    step_d [LANES][RW];
  logic [2*RW-1:0]  rad0 [LANES];
  rmq_sign_t        sgn0;

  // output register
  logic             out_vld_q;
  logic [FIELD_W-1:0] quat_d [LANES];
  logic [FIELD_W-1:0] quat_q [LANES];
  logic             adv;
  logic             lane_neg [LANES];

  // one restoring root step: bring down two radicand bits, try root*4+1
  function automatic logic [TW-1:0] sqrt_step(logic [RW+1:0] rem, logic [RW-1:0] root,
                                              logic [1:0] pair);
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    cur   = {rem[RW-1:0], pair};
    trial = {root, 2'b01};
    if (cur >= trial) return {cur - trial, root[RW-2:0], 1'b1};
    else              return {cur, root[RW-2:0], 1'b0};
  endfunction

  assign adv         = !out_vld_q || quat_o.ready;
  assign pop_ready_o = adv;
  assign sgn0        = rmq_sign_t'(pop_data_i[EW-1 -: SIGN_W]);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rad0[l] = (2 * RW)'(pop_data_i[(LANES - l) * UW - 1 -: UW]) << FRAC_BITS;
      step_d[l][0] = sqrt_step('0, '0, rad0[l][2*RW-1 -: 2]);
      for (int s = 1; s < RW; s++) begin
        step_d[l][s] = sqrt_step(rem_q[l][s-1], root_q[l][s-1],
                                 rad_q[l][s-1][2*RW-1 -: 2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '{default: 1'b0};
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pop_valid_i;
      for (int s = 1; s < RW; s++) vld_q[s] <= vld_q[s-1];
      out_vld_q <= vld_q[RW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn_q[0] <= sgn0;
      for (int s = 1; s < RW; s++) sgn_q[s] <= sgn_q[s-1];
      for (int l = 0; l < LANES; l++) begin
        rad_q[l][0] <= rad0[l] << 2;
        for (int s = 1; s < RW - 1; s++) rad_q[l][s] <= rad_q[l][s-1] << 2;
        for (int s = 0; s < RW - 1; s++) rem_q[l][s] <= step_d[l][s][TW-1 -: RW+2];
        for (int s = 0; s < RW; s++)     root_q[l][s] <= step_d[l][s][RW-1:0];
        quat_q[l] <= quat_d[l];
      end
    end
  end

  assign lane_neg[LANE_W] = 1'b0;
  assign lane_neg[LANE_X] = sgn_q[RW-1].neg_x;
  assign lane_neg[LANE_Y] = sgn_q[RW-1].neg_y;
  assign lane_neg[LANE_Z] = sgn_q[RW-1].neg_z;

  always_comb begin
    logic [XW-1:0]      half;
    logic [FIELD_W-2:0] mag;
    logic [FIELD_W-1:0] val;
    for (int l = 0; l < LANES; l++) begin
      half      = XW'(root_q[l][RW-1][RW-1:1]);
      mag       = (half > XW'(MAG_MAX)) ? MAG_MAX : half[FIELD_W-2:0];
      val       = {1'b0, mag};
      quat_d[l] = lane_neg[l] ? (~val + FIELD_W'(1)) : val;
    end
  end

  assign quat_o.valid  = out_vld_q;
  assign quat_o.quat_w = quat_q[LANE_W];
  assign quat_o.quat_x = quat_q[LANE_X];
  assign quat_o.quat_y = quat_q[LANE_Y];
  assign quat_o.quat_z = quat_q[LANE_Z];

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion_unit.sv =====
// Top level of the rotation matrix to quaternion unit: front end, queue and
// root pipeline. Uses rmq_pkg, rmq_if, rmq_front, rmq_queue, rmq_back.
//
//  channel  dir  handshake     payload
//  mat_i    in   valid/ready   nine signed Q2.14 entries, right/up/fwd rows
//  quat_o   out  valid/ready   quat_w, quat_x, quat_y, quat_z, signed Q2.14
//
// One transaction per cycle in steady state, in both directions, while quat_o is not stalled.
// From acceptance, a transaction passes through the queue, the pipeline of
//   one-bit square-root stages and the output register to quat_o.valid; RW,
//   the root width of those stages, is (sum width + FRAC_BITS)/2.
// Reset clears the queue count and the stage valid bits at once; no sweep.
// A stall on quat_o freezes the back end; the queue fills and mat_i.ready is
//   low in every cycle in which the queue holds QUEUE_DEPTH transactions.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS   = rmq_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmq_mat_if.sink    mat_i,
  rmq_quat_if.source quat_o
);
  import rmq_pkg::*;

  localparam int EW = entry_width(FRAC_BITS);

  // front -> queue
  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  // queue -> back
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;

  // Classification: sums clamped at zero, signs from the off-diagonal
  // differences. Purely combinational, registered by the queue.
  rmq_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .mat_i        (mat_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouples acceptance from the root pipeline so either side can stall.
  rmq_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Four lanes of root stages, then halving, saturation to 32767 and sign.
  rmq_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .quat_o      (quat_o)
  );

endmodule

// ===== hw/rtl/rmq_checker.sv =====
// Port-level assertions of the rotation matrix to quaternion unit, bound to
// the top level. Uses the macros header.
`include "rotation_matrix_to_quaternion_unit_macros.svh"

module rmq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        quat_valid_i,
  input logic        quat_ready_i,
  input logic [15:0] quat_w_i,
  input logic [15:0] quat_x_i,
  input logic [15:0] quat_y_i,
  input logic [15:0] quat_z_i
);

  `RMQ_ASSERT_HOLD(a_valid_hold, clk_i, rst_ni, quat_valid_i, quat_ready_i, quat_valid_i, "quaternion dropped while stalled")
  `RMQ_ASSERT_HOLD(a_data_hold, clk_i, rst_ni, quat_valid_i, quat_ready_i, $stable({quat_w_i, quat_x_i, quat_y_i, quat_z_i}), "quaternion changed while stalled")
  `RMQ_ASSERT(a_w_nonneg, clk_i, rst_ni, quat_valid_i |-> !quat_w_i[15], "scalar part negative")
  `RMQ_ASSERT(a_no_minmag, clk_i, rst_ni, quat_valid_i |-> (quat_x_i != 16'h8000 && quat_y_i != 16'h8000 && quat_z_i != 16'h8000), "vector part beyond saturation")

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .quat_valid_i (quat_o.valid),
  .quat_ready_i (quat_o.ready),
  .quat_w_i     (quat_o.quat_w),
  .quat_x_i     (quat_o.quat_x),
  .quat_y_i     (quat_o.quat_y),
  .quat_z_i     (quat_o.quat_z)
);

// ===== bench/rmq_quat_checker.sv =====
`timescale 1ns / 100ps
// Checker for the rotation matrix to quaternion unit: watches both channels,
// predicts each quaternion and compares it. Needs rmq_pkg and rmq_if.
module rmq_quat_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rmq_mat_if   mat_i,
  rmq_quat_if  quat_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  import rmq_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct {
    logic signed [FIELD_W-1:0] w;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } quat_t;

  quat_t expected_quats[$];

  // bit-by-bit integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // half root of a diagonal sum, clamped below at zero, saturated above
  function automatic longint halved_root(longint sum);
    longint unsigned mag;
    if (sum < 0) sum = 0;
    mag = floor_sqrt(longint'(sum) << FRAC) >> 1;
    if (mag > MAG_MAX) mag = MAG_MAX;
    return longint'(mag);
  endfunction

  function automatic quat_t quat_from_matrix(
    input logic signed [FIELD_W-1:0] rx, ry, rz,
    input logic signed [FIELD_W-1:0] ux, uy, uz,
    input logic signed [FIELD_W-1:0] fx, fy, fz
  );
    longint one;
    longint w, x, y, z;
    quat_t  q;
    one = longint'(1) << FRAC;
    w = halved_root(one + rx + uy + fz);
    x = halved_root(one + rx - uy - fz);
    y = halved_root(one - rx + uy - fz);
    z = halved_root(one - rx - uy + fz);
    // zero difference keeps the positive sign
    if (longint'(fy) - longint'(uz) < 0) x = -x;
    if (longint'(rz) - longint'(fx) < 0) y = -y;
    if (longint'(ux) - longint'(ry) < 0) z = -z;
    q.w = w[FIELD_W-1:0];
    q.x = x[FIELD_W-1:0];
    q.y = y[FIELD_W-1:0];
    q.z = z[FIELD_W-1:0];
    return q;
  endfunction

  task automatic compare_part(input string name, input logic signed [FIELD_W-1:0] want,
                              input logic signed [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni) begin
      if (mat_i.valid && mat_i.ready) begin
        expected_quats.push_back(quat_from_matrix(
          mat_i.m_right_x, mat_i.m_right_y, mat_i.m_right_z,
          mat_i.m_up_x, mat_i.m_up_y, mat_i.m_up_z,
          mat_i.m_fwd_x, mat_i.m_fwd_y, mat_i.m_fwd_z));
      end
      if (quat_i.valid && quat_i.ready) begin
        if (expected_quats.size() == 0) begin
          $error("quaternion with no matrix outstanding: w=%0d x=%0d y=%0d z=%0d",
                 quat_i.quat_w, quat_i.quat_x, quat_i.quat_y, quat_i.quat_z);
          fail_count_o++;
        end else begin
          want = expected_quats.pop_front();
          compare_part("quat_w", want.w, quat_i.quat_w);
          compare_part("quat_x", want.x, quat_i.quat_x);
          compare_part("quat_y", want.y, quat_i.quat_y);
          compare_part("quat_z", want.z, quat_i.quat_z);
          checked_o++;
        end
      end
    end
    pending_o = expected_quats.size();
  end

endmodule

// ===== bench/tb_rotation_matrix_to_quaternion_unit.sv =====
`timescale 1ns / 100ps
// Top of the bench for the rotation matrix to quaternion unit: clock, reset,
// matrix stimulus, output back-pressure and verdict. Needs rmq_pkg, rmq_if,
// the unit itself and rmq_quat_checker.
module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 7;
  // delay through the root pipeline at the default fraction width
  localparam int LATENCY          = 17;
  localparam int DRAIN_CYCLES     = 2 * LATENCY;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int N_PHASES         = 5;
  // leave ample headroom above the slowest run
  localparam int CYCLE_LIMIT      = 200_000;
  localparam int ONE_Q14          = 1 << FRAC_BITS_DEF;

  typedef struct {
    logic signed [FIELD_W-1:0] rx, ry, rz;
    logic signed [FIELD_W-1:0] ux, uy, uz;
    logic signed [FIELD_W-1:0] fx, fy, fz;
  } mat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #HALF_PERIOD clk_i = ~clk_i;

  // idling mix per phase: percentage of cycles the source holds off and the
  // sink stalls. Phases: none, source only, sink only, both, none again.
  int phase_idle[N_PHASES]  = '{0, 54, 0, 36, 0};
  int phase_stall[N_PHASES] = '{0, 0, 54, 36, 0};
  int source_idle_pct = 0;
  int sink_stall_pct  = 0;

  int matrices_sent;
  int directed_count;
  int cycle_count;
  int fail_count;
  int pending_quats;
  int checked_quats;

  rmq_mat_if  mat_ch ();
  rmq_quat_if quat_ch ();

  rotation_matrix_to_quaternion_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mat_i  (mat_ch),
    .quat_o (quat_ch)
  );

  rmq_quat_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mat_i        (mat_ch),
    .quat_i       (quat_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_quats),
    .checked_o    (checked_quats)
  );

  // ---------------------------------------------------------------------------
  // Matrix builders
  // ---------------------------------------------------------------------------

  function automatic mat_t make_matrix(int rx, int ry, int rz, int ux, int uy, int uz,
                                       int fx, int fy, int fz);
    mat_t m;
    m.rx = rx[FIELD_W-1:0]; m.ry = ry[FIELD_W-1:0]; m.rz = rz[FIELD_W-1:0];
    m.ux = ux[FIELD_W-1:0]; m.uy = uy[FIELD_W-1:0]; m.uz = uz[FIELD_W-1:0];
    m.fx = fx[FIELD_W-1:0]; m.fy = fy[FIELD_W-1:0]; m.fz = fz[FIELD_W-1:0];
    return m;
  endfunction

  function automatic mat_t any_matrix();
    return make_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
  endfunction

  // one entry biased to the corners of the range and the unit values
  function automatic int corner_entry();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2: return -32767;
      3: return 0;
      4: return 1;
      5: return -1;
      6: return ONE_Q14;
      7: return -ONE_Q14;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic mat_t corner_matrix();
    return make_matrix(corner_entry(), corner_entry(), corner_entry(),
                       corner_entry(), corner_entry(), corner_entry(),
                       corner_entry(), corner_entry(), corner_entry());
  endfunction

  function automatic real unit_draw();
    return real'(int'($urandom_range(20000)) - 10000) / 10000.0;
  endfunction

  // real entry to Q2.14 with rounding, optional jitter and saturation
  function automatic int to_q14(real v, int jitter);
    int r;
    r = $rtoi(v * ONE_Q14 + ((v >= 0.0) ? 0.5 : -0.5));
    if (jitter > 0) r += int'($urandom_range(2 * jitter)) - jitter;
    if (r > 32767)  r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // A proper rotation from a random unit quaternion. Rows are right, up, fwd,
  // so the sign differences come out as 4xw, 4yw and 4zw. Knocking one part
  // out without jitter makes the matching differences exactly zero.
  function automatic mat_t rotation_matrix();
    real  qw, qx, qy, qz, n;
    int   knock, jitter;
    do begin
      qw = unit_draw(); qx = unit_draw(); qy = unit_draw(); qz = unit_draw();
      knock = $urandom_range(7);
      case (knock)
        0: qw = 0.0;
        1: qx = 0.0;
        2: qy = 0.0;
        3: qz = 0.0;
        default: ;
      endcase
      n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    end while (n < 0.01);
    qw /= n; qx /= n; qy /= n; qz /= n;
    if (knock < 4) jitter = 0;
    else begin
      case ($urandom_range(2))
        0: jitter = 0;
        1: jitter = 3;
        default: jitter = 96;
      endcase
    end
    return make_matrix(
      to_q14(1.0 - 2.0 * (qy * qy + qz * qz), jitter),
      to_q14(2.0 * (qx * qy - qz * qw), jitter),
      to_q14(2.0 * (qx * qz + qy * qw), jitter),
      to_q14(2.0 * (qx * qy + qz * qw), jitter),
      to_q14(1.0 - 2.0 * (qx * qx + qz * qz), jitter),
      to_q14(2.0 * (qy * qz - qx * qw), jitter),
      to_q14(2.0 * (qx * qz - qy * qw), jitter),
      to_q14(2.0 * (qy * qz + qx * qw), jitter),
      to_q14(1.0 - 2.0 * (qx * qx + qy * qy), jitter));
  endfunction

  // half genuine rotations, the rest raw noise and corner-heavy matrices
  function automatic mat_t random_matrix();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5)      return rotation_matrix();
    else if (pick < 8) return any_matrix();
    else               return corner_matrix();
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  task automatic drive_payload(input mat_t m);
    mat_ch.m_right_x <= m.rx; mat_ch.m_right_y <= m.ry; mat_ch.m_right_z <= m.rz;
    mat_ch.m_up_x    <= m.ux; mat_ch.m_up_y    <= m.uy; mat_ch.m_up_z    <= m.uz;
    mat_ch.m_fwd_x   <= m.fx; mat_ch.m_fwd_y   <= m.fy; mat_ch.m_fwd_z   <= m.fz;
  endtask

  // Called just after the clock rises. Holds off at random (junk on the payload
  // while valid is low), then offers the matrix until the transaction is taken.
  // valid is left high so back-to-back transactions need no toggling.
  task automatic send_matrix(input mat_t m);
    while ($urandom_range(99) < source_idle_pct) begin
      mat_ch.valid <= 1'b0;
      drive_payload(any_matrix());
      @(posedge clk_i);
    end
    mat_ch.valid <= 1'b1;
    drive_payload(m);
    @(posedge clk_i);
    while (!mat_ch.ready) @(posedge clk_i);
    matrices_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: ready is redrawn every edge, low during reset
  // ---------------------------------------------------------------------------

  initial begin
    quat_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      quat_ch.ready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d quaternions outstanding",
               cycle_count, pending_quats);
      $display("[rotation_matrix_to_quaternion_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    mat_t directed_set[$];

    mat_ch.valid <= 1'b0;
    drive_payload(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));

    // identity and the all-zero matrix
    directed_set.push_back(make_matrix(ONE_Q14, 0, 0, 0, ONE_Q14, 0, 0, 0, ONE_Q14));
    directed_set.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // every entry at the top, then at the bottom of the range
    directed_set.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                       32767, 32767, 32767));
    directed_set.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768));
    // largest sum on each lane in turn, signs pushed to both ends
    directed_set.push_back(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    directed_set.push_back(make_matrix(32767, 0, 0, 0, -32768, -32768, 0, 32767, -32768));
    directed_set.push_back(make_matrix(-32768, 0, -32768, 0, 32767, 0, 32767, 0, -32768));
    directed_set.push_back(make_matrix(-32768, 32767, 0, -32768, -32768, 0, 0, 0, 32767));
    // half turns about x, y and z: scalar part goes to zero
    directed_set.push_back(make_matrix(ONE_Q14, 0, 0, 0, -ONE_Q14, 0, 0, 0, -ONE_Q14));
    directed_set.push_back(make_matrix(-ONE_Q14, 0, 0, 0, ONE_Q14, 0, 0, 0, -ONE_Q14));
    directed_set.push_back(make_matrix(-ONE_Q14, 0, 0, 0, -ONE_Q14, 0, 0, 0, ONE_Q14));
    // quarter turn about x and its inverse: x part positive, then negative
    directed_set.push_back(make_matrix(ONE_Q14, 0, 0, 0, 0, -ONE_Q14, 0, ONE_Q14, 0));
    directed_set.push_back(make_matrix(ONE_Q14, 0, 0, 0, 0, ONE_Q14, 0, -ONE_Q14, 0));
    // equal off-diagonal pairs: every sign difference zero, all parts positive
    directed_set.push_back(make_matrix(4000, 123, -7000, 123, -2000, 5000,
                                       -7000, 5000, 1000));
    // trace two below minus one: scalar sum negative, clamped to zero
    directed_set.push_back(make_matrix(-5462, 0, 0, 0, -5462, 0, 0, 0, -5462));
    // scalar sum exactly zero
    directed_set.push_back(make_matrix(-ONE_Q14, 0, 0, 0, 0, 0, 0, 0, 0));
    // sign differences of minus one
    directed_set.push_back(make_matrix(0, 1, -1, 0, 0, 1, 0, 0, 0));
    // widest sign differences, one way and the other
    directed_set.push_back(make_matrix(0, -32768, -32768, 32767, 0, -32768, 32767, 32767, 0));
    directed_set.push_back(make_matrix(0, 32767, 32767, -32768, 0, 32767, -32768, -32768, 0));
    // alternating bit patterns
    directed_set.push_back(make_matrix('h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555,
                                       'h5555, 'h5555, 'h5555));
    directed_set.push_back(make_matrix('hAAAA, 'hAAAA, 'hAAAA, 'hAAAA, 'hAAAA, 'hAAAA,
                                       'hAAAA, 'hAAAA, 'hAAAA));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with no idling
    foreach (directed_set[i]) send_matrix(directed_set[i]);
    directed_count = directed_set.size();

    // random part, one idling mix per phase
    for (int p = 0; p < N_PHASES; p++) begin
      source_idle_pct = phase_idle[p];
      sink_stall_pct  = phase_stall[p];
      repeat (RANDOM_PER_PHASE) send_matrix(random_matrix());
    end
    mat_ch.valid   <= 1'b0;
    sink_stall_pct  = 0;

    // drain, then watch a little longer for stray transactions
    while (pending_quats != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d matrices (%0d directed), checked %0d quaternions", matrices_sent,
             directed_count, checked_quats);
    $display("idling mixes: none, source 54%%, sink 54%%, both 36%%, none; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("[rotation_matrix_to_quaternion_unit] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion_unit] ERROR");
    end
    $finish;
  end

endmodule
